/* hw/rtl/ggc_pkg.sv */
package ggc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_BITS_DEF      = 20;
  localparam int NUM_ATAN          = 24;

  localparam logic [15:0] DIST_SCALE = 16'd39797;
  localparam logic [15:0] ANGLE_PI   = 16'h8000;
  localparam logic [14:0] TURN_LIMIT = 15'd16384;

  localparam logic [11:0] TOL_RST        = 12'd410;
  localparam logic [11:0] SPEED_GAIN_RST = 12'd819;
  localparam logic [11:0] SPD_CAP_RST    = 12'd819;
  localparam logic [14:0] TURN_CAP_RST   = 15'd7282;
  localparam logic [11:0] STOP_SPEED_RST = 12'd41;

  typedef enum logic [2:0] {
    REG_GOAL_X     = 3'd0,
    REG_GOAL_Y     = 3'd1,
    REG_TOL        = 3'd2,
    REG_SPEED_GAIN = 3'd3,
    REG_SPD_CAP    = 3'd4,
    REG_TURN_CAP   = 3'd5,
    REG_STOP_SPEED = 3'd6
  } cfg_reg_t;

  // atan(2^-i) in binary angle units, 32768 = pi
  function automatic logic [15:0] atan_lut(input int idx);
    logic [15:0] v;
    case (idx)
      0:       v = 16'd8192;
      1:       v = 16'd4836;
      2:       v = 16'd2555;
      3:       v = 16'd1297;
      4:       v = 16'd651;
      5:       v = 16'd326;
      6:       v = 16'd163;
      7:       v = 16'd81;
      8:       v = 16'd41;
      9:       v = 16'd20;
      10:      v = 16'd10;
      11:      v = 16'd5;
      12:      v = 16'd3;
      13:      v = 16'd1;
      14:      v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/go_to_goal_controller.sv */
// pipeline: CORDIC_STAGES + 5 register stages
// throughput: one transaction per cycle while out_ready is high; a stalled result holds
//   the pipeline only once every stage behind it is full
// reset: synchronous active-low rst_n clears all stage valid bits and loads the
//   configuration registers with their reset values
module go_to_goal_controller
  import ggc_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int POS_BITS      = POS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [2:0]                           cfg_addr,
  input  logic [((POS_BITS > 15) ? POS_BITS : 15)-1:0] cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [POS_BITS-1:0]           in_pos_x,
  input  logic signed [POS_BITS-1:0]           in_pos_y,
  input  logic signed [15:0]                   in_heading,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [11:0]                          out_fwd_speed,
  output logic signed [15:0]                   out_turn_cmd,
  output logic                                 out_reached
);

  localparam int W    = POS_BITS + 3;
  localparam int DW   = POS_BITS + 2;
  localparam int PW   = DW + 16;
  localparam int SW   = DW + 12;
  localparam int NSTG = CORDIC_STAGES + 5;
  localparam int S_MUL  = CORDIC_STAGES + 2;
  localparam int S_SPD  = CORDIC_STAGES + 3;
  localparam int S_OUT  = CORDIC_STAGES + 4;

  // configuration
  logic signed [POS_BITS-1:0] goal_x_r, goal_y_r;
  logic [11:0] tol_r, speed_gain_r, spd_cap_r, stop_speed_r;
  logic [14:0] turn_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      tol_r        <= TOL_RST;
      speed_gain_r <= SPEED_GAIN_RST;
      spd_cap_r    <= SPD_CAP_RST;
      turn_cap_r   <= TURN_CAP_RST;
      stop_speed_r <= STOP_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GOAL_X:     goal_x_r     <= cfg_wdata[POS_BITS-1:0];
        REG_GOAL_Y:     goal_y_r     <= cfg_wdata[POS_BITS-1:0];
        REG_TOL:        tol_r        <= cfg_wdata[11:0];
        REG_SPEED_GAIN: speed_gain_r <= cfg_wdata[11:0];
        REG_SPD_CAP:    spd_cap_r    <= cfg_wdata[11:0];
        REG_TURN_CAP:   turn_cap_r   <= cfg_wdata[14:0];
        REG_STOP_SPEED: stop_speed_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage load enables
  logic v_r [NSTG];
  logic en  [NSTG];

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) v_r[k] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

  // stage 0: offsets to goal
  logic signed [POS_BITS:0] dx_r, dy_r;
  logic signed [15:0]       hd0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r  <= {goal_x_r[POS_BITS-1], goal_x_r} - {in_pos_x[POS_BITS-1], in_pos_x};
      dy_r  <= {goal_y_r[POS_BITS-1], goal_y_r} - {in_pos_y[POS_BITS-1], in_pos_y};
      hd0_r <= in_heading;
    end
  end

  // cordic vectoring pipeline, index 0 holds the pre-rotated vector
  logic signed [W-1:0] cx_r [CORDIC_STAGES+1];
  logic signed [W-1:0] cy_r [CORDIC_STAGES+1];
  logic [15:0]         cz_r [CORDIC_STAGES+1];
  logic signed [15:0]  hd_r [CORDIC_STAGES+1];

  logic signed [W-1:0] dx_ext, dy_ext;
  assign dx_ext = W'(dx_r);
  assign dy_ext = W'(dy_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (dx_r[POS_BITS]) begin
        cx_r[0] <= -dx_ext;
        cy_r[0] <= -dy_ext;
        cz_r[0] <= ANGLE_PI;
      end else begin
        cx_r[0] <= dx_ext;
        cy_r[0] <= dy_ext;
        cz_r[0] <= '0;
      end
      hd_r[0] <= hd0_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [W-1:0] xs, ys, x_nxt, y_nxt;
    logic [15:0]         z_nxt;

    always_comb begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      if (!cy_r[i][W-1]) begin
        x_nxt = cx_r[i] + ys;
        y_nxt = cy_r[i] - xs;
        z_nxt = cz_r[i] + atan_lut(i);
      end else begin
        x_nxt = cx_r[i] - ys;
        y_nxt = cy_r[i] + xs;
        z_nxt = cz_r[i] - atan_lut(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en[i+2]) begin
        cx_r[i+1] <= x_nxt;
        cy_r[i+1] <= y_nxt;
        cz_r[i+1] <= z_nxt;
        hd_r[i+1] <= hd_r[i];
      end
    end
  end

  // gain correction multiply, heading error wrap and clamp
  logic [PW-1:0]      dprod_r;
  logic signed [15:0] err_r;
  logic signed [15:0] err_raw;
  logic [14:0]        lim;
  logic signed [16:0] err_w, lim_w;
  logic signed [15:0] err_nxt;

  always_comb begin
    err_raw = $signed(cz_r[CORDIC_STAGES] - hd_r[CORDIC_STAGES]);
    lim     = (turn_cap_r > TURN_LIMIT) ? TURN_LIMIT : turn_cap_r;
    err_w   = 17'(err_raw);
    lim_w   = $signed({2'b00, lim});
    if (err_w > lim_w) begin
      err_nxt = 16'(lim_w);
    end else if (err_w < -lim_w) begin
      err_nxt = 16'(-lim_w);
    end else begin
      err_nxt = err_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      dprod_r <= PW'(cx_r[CORDIC_STAGES][DW-1:0]) * PW'(DIST_SCALE);
      err_r   <= err_nxt;
    end
  end

  // distance times gain, tolerance compare
  logic [DW-1:0]      rng;
  logic [SW-1:0]      sprod_r;
  logic               far_r;
  logic signed [15:0] err2_r;

  assign rng = dprod_r[PW-1:16];

  always_ff @(posedge clk) begin
    if (en[S_SPD]) begin
      sprod_r <= SW'(rng) * SW'(speed_gain_r);
      far_r   <= rng > DW'(tol_r);
      err2_r  <= err_r;
    end
  end

  // saturation and stop decision
  logic [DW-1:0] spd_raw;
  logic [11:0]   speed;
  logic          stop;

  always_comb begin
    spd_raw = sprod_r[SW-1:12];
    if (!far_r) begin
      speed = '0;
    end else if (spd_raw > DW'(spd_cap_r)) begin
      speed = spd_cap_r;
    end else begin
      speed = spd_raw[11:0];
    end
    stop = speed < stop_speed_r;
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      out_fwd_speed <= stop ? 12'd0 : speed;
      out_turn_cmd  <= stop ? 16'sd0 : err2_r;
      out_reached   <= stop;
    end
  end

endmodule

/* hw/rtl/ggc_checker.sv */
module ggc_checker
  import ggc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [11:0]        out_fwd_speed,
  input logic signed [15:0] out_turn_cmd,
  input logic               out_reached
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_fwd_speed) && $stable(out_turn_cmd) && $stable(out_reached))
    else $error("result changed while stalled");

  // reached forces both commands to zero
  a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reached |-> out_fwd_speed == 12'd0 && out_turn_cmd == 16'sd0)
    else $error("reached with nonzero command");

  // turn command stays inside the clamp
  a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_turn_cmd <= 16'sd16384 && out_turn_cmd >= -16'sd16384)
    else $error("turn command out of range");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind go_to_goal_controller ggc_checker u_ggc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_fwd_speed (out_fwd_speed),
  .out_turn_cmd  (out_turn_cmd),
  .out_reached   (out_reached)
);

/* tb/sv/go_to_goal_checker.sv */
module go_to_goal_checker
  import ggc_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_addr,
  input  logic [POS_BITS_DEF-1:0]        cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [POS_BITS_DEF-1:0] in_pos_x,
  input  logic signed [POS_BITS_DEF-1:0] in_pos_y,
  input  logic signed [15:0]             in_heading,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [11:0]                    out_fwd_speed,
  input  logic signed [15:0]             out_turn_cmd,
  input  logic                           out_reached,
  output int                             pending,
  output int                             failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RANGE_SCALE = 39797;
  localparam longint TURN_CAP    = 16384;

  // atan(2^-i) in binary angle units
  localparam logic [0:23][13:0] ATAN_BAU = {
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
    14'd41,   14'd20,   14'd10,   14'd5,    14'd3,   14'd1,   14'd1,   14'd0,
    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,   14'd0,   14'd0,   14'd0
  };

  typedef struct packed {
    logic [11:0]        fwd_speed;
    logic signed [15:0] yaw_cmd;
    logic               reached;
  } steer_cmd_t;

  logic signed [POS_BITS_DEF-1:0] goal_x;
  logic signed [POS_BITS_DEF-1:0] goal_y;
  logic [11:0]                    range_tol;
  logic [11:0]                    speed_gain;
  logic [11:0]                    speed_cap;
  logic [14:0]                    turn_cap;
  logic [11:0]                    stop_speed;

  steer_cmd_t cmd_q[$];
  int         fail_cnt = 0;

  function automatic steer_cmd_t steer(input logic signed [POS_BITS_DEF-1:0] px,
                                       input logic signed [POS_BITS_DEF-1:0] py,
                                       input logic signed [15:0] hd);
    steer_cmd_t cmd;
    longint     dx, dy, x, y, z, xs, ys, rng, spd, lim, err;
    logic [15:0] wrapped;
    dx = longint'(goal_x) - longint'(px);
    dy = longint'(goal_y) - longint'(py);
    z  = 0;
    // fold the left half plane onto the right one
    if (dx < 0) begin
      x = -dx;
      y = -dy;
      z = 32768;
    end else begin
      x = dx;
      y = dy;
    end
    for (int i = 0; i < CORDIC_STAGES_DEF && i < NUM_ATAN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_BAU[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_BAU[i]);
      end
    end
    rng     = (x * RANGE_SCALE) >>> 16;
    wrapped = 16'(z - longint'(hd));
    err     = longint'($signed(wrapped));
    lim     = (longint'(turn_cap) > TURN_CAP) ? TURN_CAP : longint'(turn_cap);
    if (err > lim) err = lim;
    if (err < -lim) err = -lim;
    spd = 0;
    if (rng > longint'(range_tol)) begin
      spd = (rng * longint'(speed_gain)) >>> 12;
      if (spd > longint'(speed_cap)) spd = longint'(speed_cap);
    end
    if (spd < longint'(stop_speed)) begin
      cmd.fwd_speed = 12'd0;
      cmd.yaw_cmd   = 16'sd0;
      cmd.reached   = 1'b1;
    end else begin
      cmd.fwd_speed = 12'(spd);
      cmd.yaw_cmd   = 16'(err);
      cmd.reached   = 1'b0;
    end
    return cmd;
  endfunction

  always @(posedge clk) begin
    steer_cmd_t want;
    if (!rst_n) begin
      goal_x     = '0;
      goal_y     = '0;
      range_tol  = TOL_RST;
      speed_gain = SPEED_GAIN_RST;
      speed_cap  = SPD_CAP_RST;
      turn_cap   = TURN_CAP_RST;
      stop_speed = STOP_SPEED_RST;
      cmd_q.delete();
    end else begin
      // predict with the settings in force before any write at this edge
      if (in_valid && in_ready) cmd_q.push_back(steer(in_pos_x, in_pos_y, in_heading));
      if (cfg_we) begin
        case (cfg_addr)
          REG_GOAL_X:     goal_x     = cfg_wdata;
          REG_GOAL_Y:     goal_y     = cfg_wdata;
          REG_TOL:        range_tol  = cfg_wdata[11:0];
          REG_SPEED_GAIN: speed_gain = cfg_wdata[11:0];
          REG_SPD_CAP:    speed_cap  = cfg_wdata[11:0];
          REG_TURN_CAP:   turn_cap   = cfg_wdata[14:0];
          REG_STOP_SPEED: stop_speed = cfg_wdata[11:0];
          default: ;
        endcase
      end
      // score each result transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result speed %0d turn %0d reached %0d",
                     $realtime, out_fwd_speed, out_turn_cmd, out_reached);
        end else begin
          want = cmd_q.pop_front();
          if (out_fwd_speed !== want.fwd_speed || out_turn_cmd !== want.yaw_cmd ||
              out_reached !== want.reached) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: want spd %0d turn %0d rch %0d, got spd %0d turn %0d rch %0d",
                       $realtime, want.fwd_speed, want.yaw_cmd, want.reached,
                       out_fwd_speed, out_turn_cmd, out_reached);
          end
        end
      end
    end
    pending  <= cmd_q.size();
    failures <= fail_cnt;
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import ggc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DRAIN_CYCLES = 2 * (CORDIC_STAGES_DEF + 5);
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASES       = 9;
  localparam int          PHASE_ITEMS  = 95;
  localparam logic [2:0]  REG_SPARE    = 3'd7;
  localparam logic signed [19:0] POS_MIN = 20'sh80000;
  localparam logic signed [19:0] POS_MAX = 20'sh7FFFF;
  localparam logic signed [15:0] HD_MIN  = 16'sh8000;
  localparam logic signed [15:0] HD_MAX  = 16'sh7FFF;

  typedef struct packed {
    logic signed [19:0] goal_x;
    logic signed [19:0] goal_y;
    logic [11:0]        range_tol;
    logic [11:0]        speed_gain;
    logic [11:0]        speed_cap;
    logic [14:0]        turn_cap;
    logic [11:0]        stop_speed;
  } steer_cfg_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [2:0]         cfg_addr      = REG_GOAL_X;
  logic [19:0]        cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic signed [19:0] in_pos_x      = '0;
  logic signed [19:0] in_pos_y      = '0;
  logic signed [15:0] in_heading    = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [11:0]        out_fwd_speed;
  logic signed [15:0] out_turn_cmd;
  logic               out_reached;

  int         pending;
  int         failures;
  int         cycles    = 0;
  int         gap_pct   = 31;
  int         stall_pct = 63;
  steer_cfg_t cur;

  always #2 clk = ~clk;

  go_to_goal_controller uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_heading    (in_heading),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_fwd_speed (out_fwd_speed),
    .out_turn_cmd  (out_turn_cmd),
    .out_reached   (out_reached)
  );

  go_to_goal_checker steer_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_heading    (in_heading),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_fwd_speed (out_fwd_speed),
    .out_turn_cmd  (out_turn_cmd),
    .out_reached   (out_reached),
    .pending       (pending),
    .failures      (failures)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_pose(input logic signed [19:0] px, input logic signed [19:0] py,
                           input logic signed [15:0] hd);
    int gaps = 0;
    while ($urandom_range(99) < gap_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pos_x   <= px;
    in_pos_y   <= py;
    in_heading <= hd;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every pose transaction has produced its result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] addr, input logic [19:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_regs(input steer_cfg_t c);
    put_reg(REG_GOAL_X, c.goal_x);
    put_reg(REG_GOAL_Y, c.goal_y);
    put_reg(REG_TOL, 20'(c.range_tol));
    put_reg(REG_SPEED_GAIN, 20'(c.speed_gain));
    put_reg(REG_SPD_CAP, 20'(c.speed_cap));
    put_reg(REG_TURN_CAP, 20'(c.turn_cap));
    put_reg(REG_STOP_SPEED, 20'(c.stop_speed));
    // no such register, must leave the settings alone
    put_reg(REG_SPARE, 20'($urandom));
    cfg_we <= 1'b0;
    cur = c;
  endtask

  function automatic int pick(input int lo, input int hi);
    int r;
    r = int'($urandom_range(9));
    if (r == 0) return lo;
    if (r == 1) return hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic steer_cfg_t rand_cfg();
    steer_cfg_t c;
    c.goal_x     = 20'(pick(-524288, 524287));
    c.goal_y     = 20'(pick(-524288, 524287));
    c.range_tol  = 12'(pick(0, 4095));
    c.speed_gain = 12'(pick(0, 4095));
    c.speed_cap  = 12'(pick(0, 4095));
    c.turn_cap   = ($urandom_range(7) == 0) ? 15'($urandom_range(32767, 16385))
                                            : 15'(pick(0, 16384));
    c.stop_speed = ($urandom_range(3) == 0) ? 12'(pick(0, 4095)) : 12'($urandom_range(200));
    return c;
  endfunction

  // offsets of every scale, so distances land around the thresholds too
  function automatic logic signed [19:0] near(input logic signed [19:0] g);
    logic signed [31:0] off;
    off = $signed($urandom) >>> (31 - $urandom_range(20));
    return g - 20'(off);
  endfunction

  initial begin
    steer_cfg_t c;
    cur = '{20'sd0, 20'sd0, TOL_RST, SPEED_GAIN_RST, SPD_CAP_RST, TURN_CAP_RST,
            STOP_SPEED_RST};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings
    send_pose(20'sd0, 20'sd0, 16'sd0);
    send_pose(20'sd0, 20'sd0, HD_MIN);
    send_pose(POS_MIN, POS_MIN, HD_MAX);
    send_pose(POS_MAX, POS_MAX, HD_MIN);
    send_pose(POS_MAX, POS_MIN, 16'sd0);
    send_pose(POS_MIN, POS_MAX, 16'sd16384);
    send_pose(20'sd40960, 20'sd0, 16'sd0);
    // headings around the bearing plus pi, one of them gives an error of exactly pi
    for (int h = 0; h < 7; h++) send_pose(-20'sd40960, 20'sd0, 16'(16'h7FFD + 16'(h)));
    drain();

    // largest limits, no stop threshold
    write_regs('{POS_MAX, POS_MIN, 12'd4095, 12'd4095, 12'd4095, 15'd32767, 12'd0});
    send_pose(POS_MAX, POS_MIN, 16'sd12345);
    send_pose(POS_MAX, POS_MIN, HD_MAX);
    send_pose(POS_MAX, POS_MIN, HD_MIN);
    send_pose(POS_MIN, POS_MAX, HD_MIN);
    send_pose(20'sd524286, POS_MIN, 16'sd0);
    drain();

    // tolerance, speed gain, speed cap and stop speed at zero, turn limit just above the cap
    write_regs('{POS_MIN, POS_MAX, 12'd0, 12'd0, 12'd0, 15'd16385, 12'd0});
    send_pose(POS_MAX, POS_MIN, 16'sd0);
    send_pose(20'sd0, 20'sd0, 16'sd100);
    send_pose(POS_MIN, POS_MAX, 16'sd5);
    drain();

    write_regs('{20'sd0, 20'sd0, 12'd0, 12'd4095, 12'd4095, 15'd0, 12'd4095});
    send_pose(20'sd0, 20'sd409600, 16'sd0);
    send_pose(POS_MAX, POS_MAX, HD_MAX);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin
          gap_pct   = 31;
          stall_pct = 63;
        end
        1: begin
          gap_pct   = 63;
          stall_pct = 31;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      c = rand_cfg();
      write_regs(c);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        if ($urandom_range(9) < 2)
          send_pose(20'($urandom), 20'($urandom), 16'($urandom));
        else
          send_pose(near(cur.goal_x), near(cur.goal_y), 16'($urandom));
      end
      drain();
    end

    if (failures == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
